@@ hdl/ede_pkg.sv @@
`default_nettype none

package ede_pkg;

   localparam int MAX_LEN_DEFAULT = 256;

   localparam int KIND_W = 2;
   localparam int CH_W   = 8;
   localparam int DIST_W = 9;

   // Word kinds on the request channel.
   localparam logic [KIND_W-1:0] KIND_REF    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CMP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   // Strobes from the sequencer to the row store.
   typedef struct packed {
      logic rd_en;
      logic ref_we;
      logic cost_we;
   } mem_ctl_type;

endpackage

`default_nettype wire

@@ hdl/ede_row_store.sv @@
`default_nettype none

module ede_row_store
   import ede_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire mem_ctl_type                              ctl,
   input  wire logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] wr_addr,
   input  wire logic [CH_W-1:0]                          ref_wdata,
   input  wire logic [$clog2(MAX_LEN + 1)-1:0]           cost_wdata,
   input  wire logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_addr,
   output logic      [CH_W-1:0]                          ref_rdata,
   output logic      [$clog2(MAX_LEN + 1)-1:0]           cost_rdata
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LW = $clog2(MAX_LEN + 1);

   // Reference bytes and cost row entries one to MAX_LEN share an address.
   logic [CH_W-1:0] ref_mem  [MAX_LEN];
   logic [LW-1:0]   cost_mem [MAX_LEN];

   logic [CH_W-1:0] ref_rdata_ff;
   logic [LW-1:0]   cost_rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.ref_we) begin
         ref_mem[wr_addr] <= ref_wdata;
      end
      if (ctl.cost_we) begin
         cost_mem[wr_addr] <= cost_wdata;
      end
      if (ctl.rd_en) begin
         ref_rdata_ff  <= ref_mem[rd_addr];
         cost_rdata_ff <= cost_mem[rd_addr];
      end
   end

   assign ref_rdata  = ref_rdata_ff;
   assign cost_rdata = cost_rdata_ff;

endmodule

`default_nettype wire

@@ hdl/edit_distance_engine.sv @@
// Levenshtein edit distance engine with unit cost for insert, delete and substitute. Send the
// reference string first as words of kind 0, then the compared string as words of kind 1, then
// one word of kind 2, which returns the distance and the overflow flag and clears the engine for
// the next pair. A compared byte holds off further words while the engine sweeps the cost row
// over each reference byte held, and a finish word holds them off through the finish state; the
// sweep is the single read-modify-write loop through the cost row memory, which handles one
// row entry per cycle. Bytes beyond MAX_LEN in either string are dropped and raise overflow,
// and a reference byte that arrives after the compared string has begun is dropped silently.
// Word kind 3 is accepted and ignored. There is no clearing pass after reset. A waiting result
// does not hold up reference or compared bytes; only a finish word waits for the result slot.
`default_nettype none

module edit_distance_engine
   import ede_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire logic [CH_W-1:0]   req_ch,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [DIST_W-1:0] rsp_distance,
   output logic                   rsp_overflow
);

   // Address width of the two memories and width of a length or cost value.
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LW = $clog2(MAX_LEN + 1);

   // Control state.
   state_type   state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;         // reference bytes held
   logic [LW-1:0] count_ff, count_in;     // compared bytes swept; also cost row entry zero
   logic        ovf_ff, ovf_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Sweep and result payload.
   logic [AW-1:0]     idx_ff, idx_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [LW-1:0]     corner_ff, corner_in;
   logic [LW-1:0]     left_ff, left_in;
   logic [DIST_W-1:0] rsp_distance_ff, rsp_distance_in;
   logic              rsp_overflow_ff, rsp_overflow_in;

   // Row store interface.
   mem_ctl_type     mem_ctl;
   logic [AW-1:0]   wr_addr;
   logic [AW-1:0]   rd_addr;
   logic [CH_W-1:0] ref_wdata;
   logic [LW-1:0]   cost_wdata;
   logic [CH_W-1:0] ref_rdata;
   logic [LW-1:0]   cost_rdata;

   logic          req_fire;
   logic          len_full;
   logic          count_full;
   logic          sweep_start;
   logic [LW-1:0] idx_next;
   logic          sweep_last;
   logic [LW-1:0] min_lu;
   logic [LW-1:0] min_all;
   logic [LW-1:0] cell_val;
   logic [LW-1:0] fin_value;

   ede_row_store #(
      .MAX_LEN(MAX_LEN)
   ) u_row_store (
      .clock     (clock),
      .ctl       (mem_ctl),
      .wr_addr   (wr_addr),
      .ref_wdata (ref_wdata),
      .cost_wdata(cost_wdata),
      .rd_addr   (rd_addr),
      .ref_rdata (ref_rdata),
      .cost_rdata(cost_rdata)
   );

   // Only a finish word needs the result slot, so only a finish word waits for it. Once a
   // finish is taken the slot is guaranteed free when the finish state loads the result.
   assign req_ready = (state_ff == ST_IDLE) &&
                      !((req_kind == KIND_FINISH) && rsp_valid_ff && !rsp_ready);
   assign req_fire  = req_valid && req_ready;

   assign len_full    = (len_ff == LW'(MAX_LEN));
   assign count_full  = (count_ff == LW'(MAX_LEN));
   assign sweep_start = req_fire && (req_kind == KIND_CMP) && !count_full && (len_ff != '0);

   // During a sweep the memory holds the previous row entry at idx_ff, whose read data arrive
   // this cycle; the write of the new entry and the read of the next entry go to different
   // addresses, and the sequencer accepts no other word until the last write has been made.
   assign idx_next   = LW'(idx_ff) + LW'(1);
   assign sweep_last = (idx_next == len_ff);

   // One cell of the recurrence: the diagonal on a match, otherwise one more than the least of
   // the left, upper and diagonal neighbours.
   assign min_lu   = (left_ff < cost_rdata) ? left_ff : cost_rdata;
   assign min_all  = (min_lu < corner_ff) ? min_lu : corner_ff;
   assign cell_val = (ref_rdata == ch_ff) ? corner_ff : (min_all + LW'(1));

   // With an empty reference the last row entry is entry zero, which is the compared count.
   assign fin_value = (len_ff == '0) ? count_ff : cost_rdata;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind == KIND_FINISH)) begin
               state_in = ST_FINISH;
            end else if (sweep_start) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory strobes and register updates.
   always_comb begin
      mem_ctl         = '0;
      wr_addr         = idx_ff;
      rd_addr         = '0;
      ref_wdata       = req_ch;
      cost_wdata      = cell_val;
      len_in          = len_ff;
      count_in        = count_ff;
      ovf_in          = ovf_ff;
      idx_in          = idx_ff;
      ch_in           = ch_ff;
      corner_in       = corner_ff;
      left_in         = left_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_distance_in = rsp_distance_ff;
      rsp_overflow_in = rsp_overflow_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_kind)
                  KIND_REF: begin
                     // Reference bytes are only taken before the compared string begins.
                     if (count_ff == '0) begin
                        if (len_full) begin
                           ovf_in = 1'b1;
                        end else begin
                           mem_ctl.ref_we  = 1'b1;
                           mem_ctl.cost_we = 1'b1;
                           wr_addr         = AW'(len_ff);
                           cost_wdata      = len_ff + LW'(1);
                           len_in          = len_ff + LW'(1);
                        end
                     end
                  end
                  KIND_CMP: begin
                     if (count_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        // Entry zero moves from the old count to the new one; the old value
                        // is the first diagonal and the new value the first left neighbour.
                        count_in       = count_ff + LW'(1);
                        ch_in          = req_ch;
                        corner_in      = count_ff;
                        left_in        = count_ff + LW'(1);
                        idx_in         = '0;
                        mem_ctl.rd_en  = 1'b1;
                        rd_addr        = '0;
                     end
                  end
                  KIND_FINISH: begin
                     mem_ctl.rd_en = 1'b1;
                     rd_addr       = (len_ff == '0) ? '0 : AW'(len_ff - LW'(1));
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            mem_ctl.cost_we = 1'b1;
            wr_addr         = idx_ff;
            cost_wdata      = cell_val;
            corner_in       = cost_rdata;
            left_in         = cell_val;
            idx_in          = AW'(idx_next);
            if (!sweep_last) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = AW'(idx_next);
            end
         end
         ST_FINISH: begin
            rsp_valid_in    = 1'b1;
            rsp_distance_in = DIST_W'(fin_value);
            rsp_overflow_in = ovf_ff;
            len_in          = '0;
            count_in        = '0;
            ovf_in          = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      ch_ff           <= ch_in;
      corner_ff       <= corner_in;
      left_ff         <= left_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // A sweep only ever runs over a non-empty reference and stays inside it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> ((len_ff != '0) && (LW'(idx_ff) < len_ff)))
      else $error("sweep index outside the reference string");

   // An accepted finish word is followed by the finish cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_kind == KIND_FINISH)) |=> (state_ff == ST_FINISH))
      else $error("finish word did not reach the finish cycle");

   // The result slot is free when the finish cycle loads it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !rsp_valid_ff)
      else $error("result slot still occupied at finish");

   // Finishing presents a result and leaves the engine cleared.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=>
         (rsp_valid_ff && (len_ff == '0) && (count_ff == '0) && !ovf_ff))
      else $error("finish did not present a result and clear the engine");

   // The compared count moves only by one and only on a taken compared byte, or back to zero.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ((count_ff == '0) || (count_ff == $past(count_ff) + LW'(1))))
      else $error("compared count moved unexpectedly");

endmodule

`default_nettype wire

@@ tb/edit_distance_checker.sv @@
module edit_distance_checker
   import ede_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire logic [CH_W-1:0]   req_ch,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [DIST_W-1:0] rsp_distance,
   input  wire logic              rsp_overflow,
   output int                     failures,
   output int                     pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              overflow;
   } distance_word_type;

   // Own copy of the engine state: reference text, cost row and counts.
   logic [CH_W-1:0]   ref_text [MAX_LEN];
   int                cost_row [MAX_LEN+1];
   int                ref_held;
   int                compared_held;
   logic              overflow_seen;
   distance_word_type expected_distances [$];
   int                mismatch_count;

   task automatic clear_pair();
      cost_row[0]   = 0;
      ref_held      = 0;
      compared_held = 0;
      overflow_seen = 1'b0;
   endtask

   // One compared byte sweeps the row once, carrying the diagonal corner along.
   task automatic sweep_cost_row(input logic [CH_W-1:0] c);
      int corner;
      int upper;
      int best;
      corner = cost_row[0];
      cost_row[0] = compared_held + 1;
      for (int j = 0; j < ref_held; j++) begin
         upper = cost_row[j+1];
         if (ref_text[j] == c) begin
            cost_row[j+1] = corner;
         end else begin
            best = cost_row[j];
            if (upper < best) best = upper;
            if (corner < best) best = corner;
            cost_row[j+1] = best + 1;
         end
         corner = upper;
      end
   endtask

   task automatic predict_distance(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] c);
      distance_word_type result;
      case (kind)
         KIND_REF: begin
            // Reference bytes after the compared string has begun are dropped quietly.
            if (compared_held == 0) begin
               if (ref_held >= MAX_LEN) begin
                  overflow_seen = 1'b1;
               end else begin
                  ref_text[ref_held]   = c;
                  cost_row[ref_held+1] = ref_held + 1;
                  ref_held++;
               end
            end
         end
         KIND_CMP: begin
            if (compared_held >= MAX_LEN) begin
               overflow_seen = 1'b1;
            end else begin
               sweep_cost_row(c);
               compared_held++;
            end
         end
         KIND_FINISH: begin
            result.distance = DIST_W'(cost_row[ref_held]);
            result.overflow = overflow_seen;
            expected_distances.push_back(result);
            clear_pair();
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      distance_word_type want;
      if (reset) begin
         clear_pair();
         expected_distances.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && req_ready) predict_distance(req_kind, req_ch);
         if (rsp_valid && rsp_ready) begin
            if (expected_distances.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result word: distance %0d overflow %0b",
                           $realtime, rsp_distance, rsp_overflow);
            end else begin
               want = expected_distances.pop_front();
               if (rsp_distance !== want.distance || rsp_overflow !== want.overflow) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: result mismatch: distance %0d (expected %0d), %s %0b (%s %0b)",
                              $realtime, rsp_distance, want.distance,
                              "overflow", rsp_overflow, "expected", want.overflow);
               end
            end
         end
      end
      failures <= mismatch_count;
      pending  <= expected_distances.size();
   end

endmodule

@@ tb/tb_edit_distance_engine.sv @@
module tb_edit_distance_engine;

   import ede_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The package names only the three live kinds; the fourth code is accepted and ignored.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int ITEM_TARGET  = 1600;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 300;
   localparam int DRAIN_LIMIT  = 100000;

   typedef enum int {
      PACE_STEADY,
      PACE_SENDER_GAPS,
      PACE_RECEIVER_STALLS,
      PACE_BOTH
   } pacing_type;

   logic              clock;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_ready;
   logic [KIND_W-1:0] req_kind     = KIND_REF;
   logic [CH_W-1:0]   req_ch       = '0;
   logic              rsp_valid;
   logic              rsp_ready    = 1'b0;
   logic [DIST_W-1:0] rsp_distance;
   logic              rsp_overflow;

   int failures;
   int pending;

   // Pacing knobs, read by the sender task and by the receiver process.
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   // The stimulus asks for a long receiver hold-off by bumping holds_asked; the receiver
   // process serves each request itself and counts the stretch in its own cycles.
   int holds_asked  = 0;
   int holds_served = 0;
   // Words taken by the engine, apart from ignored kind-3 words, which are not counted.
   int words_sent   = 0;

   edit_distance_engine dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_ch       (req_ch),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_distance (rsp_distance),
      .rsp_overflow (rsp_overflow)
   );

   edit_distance_checker distance_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_ch       (req_ch),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_distance (rsp_distance),
      .rsp_overflow (rsp_overflow),
      .failures     (failures),
      .pending      (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net: the slowest legitimate run is well under a tenth of this.
   initial begin
      #20ms;
      $display("edit_distance_engine test failed");
      $finish;
   end

   // Result side. Outside a hold-off, ready is redrawn every cycle against the stall rate
   // of the current phase, so stalls land on every stage of the engine's work.
   initial begin
      forever begin
         @(posedge clock);
         if (holds_asked != holds_served) begin
            holds_served++;
            rsp_ready <= 1'b0;
            for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   task automatic set_pacing(input pacing_type pace);
      case (pace)
         PACE_STEADY: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         PACE_SENDER_GAPS: begin
            sender_idle_pct    = 47;
            receiver_stall_pct = 0;
         end
         PACE_RECEIVER_STALLS: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 47;
         end
         default: begin
            sender_idle_pct    = 25;
            receiver_stall_pct = 25;
         end
      endcase
   endtask

   // Offers one word and returns just after the edge at which it was taken. Valid is only
   // dropped when the sender chooses to idle, so back-to-back words never see valid toggle
   // within a single time step.
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_ch    <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind != KIND_UNUSED) words_sent++;
   endtask

   // A narrow alphabet of four letters makes matches common, so the diagonal path of the
   // row update is exercised as much as the insert, delete and substitute paths.
   function automatic logic [CH_W-1:0] pick_byte(input bit narrow);
      return narrow ? CH_W'(8'h61 + $urandom_range(0, 3)) : CH_W'($urandom_range(0, 255));
   endfunction

   // One pair of strings and its finish word. A noisy pair also carries ignored kind-3
   // words and reference bytes that turn up after the compared string has started.
   task automatic send_pair(input int ref_len, input int cmp_len, input bit narrow,
                            input bit noisy);
      for (int i = 0; i < ref_len; i++) begin
         send_word(KIND_REF, pick_byte(narrow));
         if (noisy && $urandom_range(0, 99) < 10) send_word(KIND_UNUSED, pick_byte(1'b0));
      end
      for (int i = 0; i < cmp_len; i++) begin
         send_word(KIND_CMP, pick_byte(narrow));
         if (noisy && $urandom_range(0, 99) < 10) send_word(KIND_REF, pick_byte(narrow));
         if (noisy && $urandom_range(0, 99) < 5) send_word(KIND_UNUSED, pick_byte(1'b0));
      end
      send_word(KIND_FINISH, pick_byte(1'b0));
   endtask

   initial begin
      int pair_index;
      int guard;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed opening, with no idling on either side.
      set_pacing(PACE_STEADY);
      // Both strings empty: the distance is zero.
      send_word(KIND_FINISH, 8'hFF);
      // Empty reference: the distance is the compared length.
      send_word(KIND_CMP, 8'h00);
      send_word(KIND_CMP, 8'hFF);
      send_word(KIND_FINISH, 8'h00);
      // Empty compared string: the distance is the reference length.
      send_word(KIND_REF, 8'hFF);
      send_word(KIND_REF, 8'h00);
      send_word(KIND_FINISH, 8'hFF);
      // The unused kind on its own gives no result.
      send_word(KIND_UNUSED, 8'hA5);
      // Identical strings, with a late reference byte and an unused word in the middle;
      // both must be dropped and leave the overflow flag clear.
      send_word(KIND_REF, 8'h5A);
      send_word(KIND_REF, 8'hFF);
      send_word(KIND_CMP, 8'h5A);
      send_word(KIND_REF, 8'h00);
      send_word(KIND_UNUSED, 8'h5A);
      send_word(KIND_CMP, 8'hFF);
      send_word(KIND_FINISH, 8'h00);
      // A single substitution between the two extreme byte values.
      send_word(KIND_REF, 8'h00);
      send_word(KIND_CMP, 8'hFF);
      send_word(KIND_FINISH, 8'h00);
      // A short classic: one substitution and a deletion.
      send_word(KIND_REF, 8'h6B);
      send_word(KIND_REF, 8'h69);
      send_word(KIND_REF, 8'h74);
      send_word(KIND_CMP, 8'h73);
      send_word(KIND_CMP, 8'h69);
      send_word(KIND_FINISH, 8'hFF);

      // The long strings come first in the random part. The reference overflows with a
      // short compared string, then the compared string overflows against a single
      // reference byte, and finally both strings fill the row exactly without overflow.
      // Only the last of these is slow.
      set_pacing(PACE_SENDER_GAPS);
      send_pair(MAX_LEN_DEFAULT + 2, 2, 1'b0, 1'b0);
      set_pacing(PACE_RECEIVER_STALLS);
      send_pair(1, MAX_LEN_DEFAULT + 2, 1'b0, 1'b0);
      set_pacing(PACE_BOTH);
      send_pair(MAX_LEN_DEFAULT, MAX_LEN_DEFAULT, 1'b1, 1'b0);

      // Back-pressure: the receiver holds off for a long stretch while short pairs keep
      // coming at full rate. The first result parks in the output slot and the next
      // finish word has to wait, which stalls the request side until the hold ends.
      set_pacing(PACE_STEADY);
      holds_asked++;
      for (int p = 0; p < 4; p++) send_pair(2, 2, 1'b1, 1'b0);

      // Bulk of the run: short pairs of random content, the pacing phase rotating every six
      // pairs. About one pair in four carries noise.
      pair_index = 0;
      while (words_sent < ITEM_TARGET) begin
         set_pacing(pacing_type'((pair_index / 6) % 4));
         send_pair($urandom_range(0, 12), $urandom_range(0, 12), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 3) == 0);
         pair_index++;
      end
      req_valid <= 1'b0;

      // Let the receiver drain what is outstanding, then give the engine time to show
      // any stray result before the verdict.
      guard = 0;
      while (pending != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && pending == 0) begin
         $display("edit_distance_engine test passed");
      end else begin
         $display("edit_distance_engine test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/ede_pkg.sv
hdl/ede_row_store.sv
hdl/edit_distance_engine.sv
tb/edit_distance_checker.sv
tb/tb_edit_distance_engine.sv
